// File: rtl/cfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants and types of the container frame checker.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned SizeW  = 27;
  localparam int unsigned HashW  = 64;

  localparam logic [31:0]      MagicWord    = 32'h314e_434c;
  localparam logic [31:0]      VersionWord  = 32'h0000_0001;
  localparam logic [HashW-1:0] FnvBasis     = 64'hcbf2_9ce4_8422_2325;
  localparam logic [SizeW-1:0] MaxPartReset = 27'd67108864;

  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatBadMagic  = 3'd1;
  localparam logic [2:0] StatBadVer    = 3'd2;
  localparam logic [2:0] StatBadSize   = 3'd3;
  localparam logic [2:0] StatShort     = 3'd4;
  localparam logic [2:0] StatExtra     = 3'd5;
  localparam logic [2:0] StatZeroHash  = 3'd6;
  localparam logic [2:0] StatMismatch  = 3'd7;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] section;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

// File: rtl/container_frame_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// container_frame_checker_core
// Checks a length-prefixed container with an FNV-1a 64 trailer, byte by byte.
// ----------------------------------------------------------------------------
// The container enters one byte per beat on the s_axis channel, tlast on its
// final byte. Every input beat gives one output beat on m_axis: the byte,
// its section in tuser (header, world, journal, trailer, beyond end) and the
// status so far in tdata; tlast marks the beat whose status is final.
// The header (magic, version, two part sizes) is checked as it arrives, the
// running hash covers every byte before the trailer and is compared with the
// stored trailer value on the last byte. The first error sticks.
// Each output beat is registered, in the cycle after its input beat; throughput
// is one byte per cycle while m_axis keeps up, set by the hash update (xor and
// shift-add multiply) feeding its own register. The output register lets a new
// beat in while the current result is taken; when m_axis_tready is low and a
// result waits, s_axis_tready drops and nothing is lost. After a tlast beat all
// frame state restarts. Reset clears it, sets max_part_bytes to 2^26; the user
// writes that via cfg_we_i only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module container_frame_checker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cfc_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic [2:0]                m_axis_tuser,   // [2:0] section
  output logic                      m_axis_tlast
);

  logic                      accept, hash_en, frame_end;
  logic [cfc_pkg::HashW-1:0] hash;
  cfc_pkg::result_t          result, res_q;
  logic                      valid_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cfc_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (hash_en),
    .clr_i  (frame_end),
    .byte_i (s_axis_tdata),
    .hash_o (hash)
  );

  cfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .hash_i      (hash),
    .hash_en_o   (hash_en),
    .frame_end_o (frame_end),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, res_q.status, res_q.out_byte};
  assign m_axis_tuser  = res_q.section;
  assign m_axis_tlast  = res_q.done_res;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted beat produced no output beat");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  a_waiting_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res_q))
    else $error("waiting result dropped or overwritten");

endmodule

// File: rtl/cfc_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_hash
// Running FNV-1a 64 hash, one byte per cycle while en_i is set, prime multiply as shift-add.
// ----------------------------------------------------------------------------
module cfc_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      clr_i,
  input  logic [7:0]                byte_i,
  output logic [cfc_pkg::HashW-1:0] hash_o
);

  logic [cfc_pkg::HashW-1:0] hash_q, hash_d, mixed;

  // prime is 2^40 + 2^8 + 0xb3
  always_comb begin
    mixed  = hash_q ^ {{(cfc_pkg::HashW-8){1'b0}}, byte_i};
    hash_d = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
           + (mixed << 4) + (mixed << 1) + mixed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= cfc_pkg::FnvBasis;
    end else if (clr_i) begin
      hash_q <= cfc_pkg::FnvBasis;
    end else if (en_i) begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

endmodule

// File: rtl/cfc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_parser
// Header, section and trailer tracking with sticky status per container.
// ----------------------------------------------------------------------------
module cfc_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cfc_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                      accept_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [cfc_pkg::HashW-1:0] hash_i,
  output logic                      hash_en_o,
  output logic                      frame_end_o,
  output cfc_pkg::result_t          result_o
);

  typedef enum logic [2:0] {
    StHeader  = 3'd0,
    StWorld   = 3'd1,
    StJournal = 3'd2,
    StTrailer = 3'd3,
    StBeyond  = 3'd4
  } stage_e;

  stage_e                    stage_q, stage_d;
  logic [cfc_pkg::SizeW-1:0] max_q;
  logic [cfc_pkg::SizeW-1:0] count_q, count_d, count_inc;
  logic [31:0]               hword_q, hword_d, hword_sh;
  logic [cfc_pkg::SizeW-1:0] wsize_q, wsize_d, jsize_q, jsize_d;
  logic [cfc_pkg::HashW-1:0] stored_q, stored_d;
  logic [2:0]                err_q, err_d, err_mid, stage_err;
  logic                      trailer_done, size_ok;

  assign hword_sh  = {byte_i, hword_q[31:8]};
  assign count_inc = count_q + 1'b1;
  assign size_ok   = (hword_sh != 32'd0)
                  && (hword_sh <= {{(32-cfc_pkg::SizeW){1'b0}}, max_q});

  always_comb begin
    stage_d      = stage_q;
    count_d      = count_inc;
    hword_d      = hword_q;
    wsize_d      = wsize_q;
    jsize_d      = jsize_q;
    stored_d     = stored_q;
    stage_err    = cfc_pkg::StatOk;
    trailer_done = 1'b0;
    case (stage_q)
      StHeader: begin
        hword_d = hword_sh;
        if (count_q == 27'd3 && hword_sh != cfc_pkg::MagicWord) begin
          stage_err = cfc_pkg::StatBadMagic;
          stage_d   = StBeyond;
        end else if (count_q == 27'd7 && hword_sh != cfc_pkg::VersionWord) begin
          stage_err = cfc_pkg::StatBadVer;
          stage_d   = StBeyond;
        end else if (count_q == 27'd11) begin
          if (size_ok) begin
            wsize_d = hword_sh[cfc_pkg::SizeW-1:0];
          end else begin
            stage_err = cfc_pkg::StatBadSize;
            stage_d   = StBeyond;
          end
        end else if (count_q == 27'd15) begin
          if (size_ok) begin
            jsize_d = hword_sh[cfc_pkg::SizeW-1:0];
            stage_d = StWorld;
            count_d = '0;
          end else begin
            stage_err = cfc_pkg::StatBadSize;
            stage_d   = StBeyond;
          end
        end
      end
      StWorld: begin
        if (count_inc >= wsize_q) begin
          stage_d = StJournal;
          count_d = '0;
        end
      end
      StJournal: begin
        if (count_inc >= jsize_q) begin
          stage_d = StTrailer;
          count_d = '0;
        end
      end
      StTrailer: begin
        stored_d = {byte_i, stored_q[cfc_pkg::HashW-1:8]};
        if (count_inc >= 27'd8) begin
          trailer_done = 1'b1;
          stage_d      = StBeyond;
          count_d      = '0;
        end
      end
      default: begin
        stage_err = cfc_pkg::StatExtra;
      end
    endcase

    err_mid = (err_q != cfc_pkg::StatOk) ? err_q : stage_err;
    err_d   = err_mid;
    if (last_i && err_mid == cfc_pkg::StatOk) begin
      if (!trailer_done) begin
        err_d = cfc_pkg::StatShort;
      end else if (stored_d == '0) begin
        err_d = cfc_pkg::StatZeroHash;
      end else if (stored_d != hash_i) begin
        err_d = cfc_pkg::StatMismatch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= cfc_pkg::MaxPartReset;
      stage_q  <= StHeader;
      count_q  <= '0;
      hword_q  <= '0;
      wsize_q  <= '0;
      jsize_q  <= '0;
      stored_q <= '0;
      err_q    <= cfc_pkg::StatOk;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        if (last_i) begin
          stage_q  <= StHeader;
          count_q  <= '0;
          hword_q  <= '0;
          wsize_q  <= '0;
          jsize_q  <= '0;
          stored_q <= '0;
          err_q    <= cfc_pkg::StatOk;
        end else begin
          stage_q  <= stage_d;
          count_q  <= count_d;
          hword_q  <= hword_d;
          wsize_q  <= wsize_d;
          jsize_q  <= jsize_d;
          stored_q <= stored_d;
          err_q    <= err_d;
        end
      end
    end
  end

  assign hash_en_o   = accept_i && (stage_q == StHeader || stage_q == StWorld
                                 || stage_q == StJournal);
  assign frame_end_o = accept_i && last_i;

  always_comb begin
    result_o.out_byte = byte_i;
    result_o.section  = stage_q;
    result_o.done_res = last_i;
    result_o.status   = err_d;
  end

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> stage_q == StHeader && err_q == cfc_pkg::StatOk)
    else $error("parser did not restart after last beat");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_i && err_q != cfc_pkg::StatOk |=> err_q == $past(err_q))
    else $error("sticky error changed within a container");

  a_payload_needs_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == StWorld || stage_q == StJournal) |-> wsize_q != '0 && jsize_q != '0)
    else $error("payload section entered without valid sizes");

endmodule

// File: verif/container_frame_checker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// container_frame_checker_core_tb
// Sends whole containers byte by byte: well-formed ones with random payloads
// and sizes, plus ones with a bad magic, version or size, a short end, extra
// bytes, a zero or wrong trailer hash, and plain noise. A scoreboard class
// tracks the frame state, predicts the beat that each input byte gives and
// checks every output beat field by field. Several max_part_bytes settings
// are used, zero, one and 2^26 among them. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module container_frame_checker_core_tb;
  import cfc_pkg::*;

  localparam int CycleLimit = 400000;

  typedef enum logic [2:0] {
    SecHeader, SecWorld, SecJournal, SecTrailer, SecBeyond
  } section_e;

  typedef enum int {
    FaultNone, FaultMagic, FaultVersion, FaultSize, FaultShort,
    FaultExtra, FaultZeroHash, FaultMismatch, FaultNoise
  } frame_fault_e;

  class frame_scoreboard;
    localparam logic [HashW-1:0] FnvPrime = 64'h0000_0100_0000_01b3;

    logic [SizeW-1:0] max_part;
    section_e         stage;
    logic [SizeW-1:0] count;
    logic [31:0]      hdr;
    logic [SizeW-1:0] world_len;
    logic [SizeW-1:0] journal_len;
    logic [HashW-1:0] run_hash;
    logic [HashW-1:0] trail_hash;
    logic [2:0]       err;
    result_t          due_q[$];
    int               errors;
    int               checked;

    function new();
      max_part = MaxPartReset;
      errors   = 0;
      checked  = 0;
      restart();
    endfunction

    static function logic [HashW-1:0] fnv_mix(logic [HashW-1:0] h, logic [7:0] b);
      return (h ^ {56'b0, b}) * FnvPrime;
    endfunction

    function void restart();
      stage       = SecHeader;
      count       = '0;
      hdr         = '0;
      world_len   = '0;
      journal_len = '0;
      run_hash    = FnvBasis;
      trail_hash  = '0;
      err         = StatOk;
    endfunction

    function void latch_error(logic [2:0] code);
      if (err == StatOk) begin
        err = code;
      end
    endfunction

    function bit size_fits(logic [31:0] v);
      return (v != 32'd0) && (v <= {5'b0, max_part});
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_beat(logic [7:0] b, logic last);
      result_t r;
      bit      trailer_full;
      trailer_full = 1'b0;
      r.section    = stage;
      if (stage == SecHeader || stage == SecWorld || stage == SecJournal) begin
        run_hash = fnv_mix(run_hash, b);
      end
      case (stage)
        SecHeader: begin
          hdr = {b, hdr[31:8]};
          if (count == 3 && hdr != MagicWord) begin
            latch_error(StatBadMagic);
            stage = SecBeyond;
          end else if (count == 7 && hdr != VersionWord) begin
            latch_error(StatBadVer);
            stage = SecBeyond;
          end else if (count == 11) begin
            if (size_fits(hdr)) begin
              world_len = hdr[SizeW-1:0];
            end else begin
              latch_error(StatBadSize);
              stage = SecBeyond;
            end
          end else if (count == 15) begin
            if (size_fits(hdr)) begin
              journal_len = hdr[SizeW-1:0];
              stage       = SecWorld;
            end else begin
              latch_error(StatBadSize);
              stage = SecBeyond;
            end
          end
          count = (stage == SecWorld) ? '0 : count + 1'b1;
        end
        SecWorld: begin
          count = count + 1'b1;
          if (count >= world_len) begin
            stage = SecJournal;
            count = '0;
          end
        end
        SecJournal: begin
          count = count + 1'b1;
          if (count >= journal_len) begin
            stage = SecTrailer;
            count = '0;
          end
        end
        SecTrailer: begin
          trail_hash = {b, trail_hash[HashW-1:8]};
          count      = count + 1'b1;
          if (count >= 8) begin
            trailer_full = 1'b1;
            stage        = SecBeyond;
            count        = '0;
          end
        end
        default: begin
          latch_error(StatExtra);
        end
      endcase
      if (last) begin
        if (trailer_full) begin
          if (trail_hash == '0) begin
            latch_error(StatZeroHash);
          end else if (trail_hash != run_hash) begin
            latch_error(StatMismatch);
          end
        end else begin
          latch_error(StatShort);
        end
      end
      r.out_byte = b;
      r.done_res = last;
      r.status   = err;
      due_q      = {due_q, r};
      if (last) begin
        restart();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $error("output beat with nothing expected: byte 0x%0h", got.out_byte);
        errors++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("section", want.section, got.section);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SizeW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] data_byte
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;   // [7:0] out_byte, [10:8] status
  logic [2:0]       m_axis_tuser;   // [2:0] section
  logic             m_axis_tlast;

  frame_scoreboard  sb;
  result_t          mon_beat;
  logic [7:0]       frame_bytes[$];
  logic [SizeW-1:0] cur_max;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_left;
  int               beats_sent;
  int               frames;
  int               settings;
  int               cycles;

  container_frame_checker_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_beat(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        mon_beat.out_byte = m_axis_tdata[7:0];
        mon_beat.status   = m_axis_tdata[10:8];
        mon_beat.section  = m_axis_tuser;
        mon_beat.done_res = m_axis_tlast;
        sb.check_beat(mon_beat);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames++;
  endtask

  // wait until every expected beat is out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_part(input logic [SizeW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_part = v;
    cur_max     = v;
    settings++;
  endtask

  function automatic void put_le(logic [63:0] v, int n);
    for (int k = 0; k < n; k++) begin
      frame_bytes = {frame_bytes, v[8*k +: 8]};
    end
  endfunction

  function automatic void put_random(int n);
    repeat (n) frame_bytes = {frame_bytes, 8'($urandom)};
  endfunction

  function automatic void make_frame(frame_fault_e kind, logic [31:0] wlen,
                                     logic [31:0] jlen);
    logic [31:0]      magic;
    logic [31:0]      ver;
    logic [31:0]      bad;
    logic [HashW-1:0] h;
    int               cut;
    magic = MagicWord;
    ver   = VersionWord;
    frame_bytes.delete();
    if (kind == FaultNoise) begin
      put_random($urandom_range(1, 20));
      return;
    end
    case (kind)
      FaultMagic: magic = magic ^ (32'd1 << $urandom_range(31));
      FaultVersion: begin
        ver = $urandom;
        if (ver == VersionWord) ver = 32'd0;
      end
      FaultSize: begin
        case ($urandom_range(2))
          0: bad = 32'd0;
          1: bad = {5'b0, cur_max} + 32'd1 + $urandom_range(3);
          default: bad = $urandom | 32'h8000_0000;
        endcase
        if ($urandom_range(1) == 0) wlen = bad;
        else jlen = bad;
      end
      FaultShort: if (cur_max > 24 && $urandom_range(2) == 0) wlen = cur_max;
      default: ;
    endcase
    put_le(magic, 4);
    put_le(ver, 4);
    put_le(wlen, 4);
    put_le(jlen, 4);
    if (kind == FaultMagic || kind == FaultVersion || kind == FaultSize) begin
      put_random($urandom_range(0, 12));
      return;
    end
    // a part too big to send in full only ever ends short
    if (wlen > 64 || jlen > 64) begin
      put_random($urandom_range(0, 8));
      return;
    end
    put_random(wlen + jlen);
    h = FnvBasis;
    foreach (frame_bytes[k]) h = frame_scoreboard::fnv_mix(h, frame_bytes[k]);
    if (kind == FaultZeroHash) h = '0;
    if (kind == FaultMismatch) h = h ^ (64'd1 << $urandom_range(63));
    put_le(h, 8);
    if (kind == FaultShort) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    if (kind == FaultExtra) put_random($urandom_range(1, 4));
  endfunction

  function automatic frame_fault_e pick_fault();
    int r;
    r = $urandom_range(99);
    if (r < 45) return FaultNone;
    if (r < 53) return FaultMagic;
    if (r < 60) return FaultVersion;
    if (r < 68) return FaultSize;
    if (r < 78) return FaultShort;
    if (r < 86) return FaultExtra;
    if (r < 91) return FaultZeroHash;
    if (r < 97) return FaultMismatch;
    return FaultNoise;
  endfunction

  initial begin
    logic [SizeW-1:0] phase_max[9];
    int               lim;
    int               rand_base;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    sb            = new();
    cur_max       = MaxPartReset;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    beats_sent    = 0;
    frames        = 0;
    settings      = 0;
    cycles        = 0;
    phase_max     = '{MaxPartReset, 27'd1, 27'd24, 27'd2, MaxPartReset,
                      27'd7, 27'd13, MaxPartReset, 27'd1000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest well-formed frame, then all-ones magic, then a lone last byte
    make_frame(FaultNone, 32'd1, 32'd1);
    send_frame();
    frame_bytes = '{8'hff, 8'hff, 8'hff, 8'hff};
    send_frame();
    frame_bytes = '{8'h00};
    send_frame();
    // zero maximum rejects every size
    set_max_part('0);
    make_frame(FaultNone, 32'd1, 32'd1);
    while (frame_bytes.size() > 12) void'(frame_bytes.pop_back());
    send_frame();

    rand_base = beats_sent;
    for (int p = 0; p < 9; p++) begin
      set_max_part(phase_max[p]);
      send_idle_pct = (p < 3) ? 24 : (p < 6) ? 59 : 0;
      recv_idle_pct = (p < 3) ? 59 : (p < 6) ? 24 : 0;
      if (p == 1 || p == 7) hold_left = 300;
      lim = (cur_max < 24) ? int'(cur_max) : 24;
      while (beats_sent < rand_base + 1450 * (p + 1) / 9) begin
        make_frame(pick_fault(), $urandom_range(1, lim), $urandom_range(1, lim));
        send_frame();
      end
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("%0d containers, %0d beats checked, %0d max_part_bytes settings",
             frames, sb.checked, settings);
    $display("header, size, short, extra, zero and wrong hash cases under stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cfc_pkg.sv
rtl/cfc_hash.sv
rtl/cfc_parser.sv
rtl/container_frame_checker_core.sv
verif/container_frame_checker_core_tb.sv
